/* src/xmodem_receiver_defines.svh */
// assertion macros for the xmodem receiver checker
// no dependencies
`ifndef XMODEM_RECEIVER_DEFINES_SVH
`define XMODEM_RECEIVER_DEFINES_SVH
// implication check reported by $error
`define XR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xmodem check failed");
// next-cycle implication check
`define XR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xmodem check failed");
`endif

/* src/xmr_pkg.sv */
// shared types and constants of the xmodem receiver
// no dependencies
`default_nettype none
package xmr_pkg;
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] CFG_PERIOD = 2'd0;
  localparam logic [1:0] CFG_CRCATT = 2'd1;
  localparam logic [1:0] CFG_CHKATT = 2'd2;
  localparam logic [1:0] CFG_MAXTO  = 2'd3;
  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;
  localparam logic [1:0] PS_NONE = 2'd0;
  localparam logic [1:0] PS_GOOD = 2'd1;
  localparam logic [1:0] PS_DUP  = 2'd2;
  localparam logic [1:0] PS_BAD  = 2'd3;

  typedef enum logic [2:0] {
    SES_IDLE = 3'd0, SES_SETUP = 3'd1, SES_RECV = 3'd2,
    SES_DONE = 3'd3, SES_ABORT = 3'd4, SES_FAIL = 3'd5
  } session_t;

  // one result item
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [6:0] payload_index;
    logic [1:0] frame_result;
    logic [2:0] session_status;
    logic       checksum_mode;
    logic       last;
  } result_t;

  // what the front hands the back for one input: up to two results
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction
endpackage
`default_nettype wire

/* src/xmodem_receiver.sv */
// top level of the xmodem receiver
// depends on xmr_pkg, xmr_front, xmr_back
// an item's results are written into the result queue when it is accepted and are shown once earlier entries retire
// throughput: one item per cycle while the result queue has room
// an item with two results takes two pops at the output side
// reset (synchronous, rst_n low) sets session idle, queue empty, registers to defaults
`default_nettype none
module xmodem_receiver #(
  parameter int QueueDepth = 4
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_push,
  output logic       in_full,
  input  wire [1:0]  in_kind,
  input  wire [7:0]  in_rx_byte,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [1:0]  cfg_index,
  input  wire [15:0] cfg_data,
  output logic       out_empty,
  input  wire        out_pop,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_payload_valid,
  output logic [7:0] out_payload_byte,
  output logic [6:0] out_payload_index,
  output logic [1:0] out_frame_result,
  output logic [2:0] out_session_status,
  output logic       out_checksum_mode,
  output logic       out_last
);
  import xmr_pkg::*;

  entry_t  ent;
  result_t res;
  logic    go;

  // front commits state on every accepted item
  assign go = in_push && !in_full;
  // config is always taken
  assign cfg_ready = 1'b1;

  xmr_front u_front (
    .clk, .rst_n, .go, .kind(in_kind), .rx_byte(in_rx_byte),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data, .ent
  );

  xmr_back #(.Depth(QueueDepth)) u_back (
    .clk, .rst_n, .push(go), .ent, .full(in_full),
    .pop(out_pop), .empty(out_empty), .res
  );

  assign out_tx_valid       = res.tx_valid;
  assign out_tx_byte        = res.tx_byte;
  assign out_payload_valid  = res.payload_valid;
  assign out_payload_byte   = res.payload_byte;
  assign out_payload_index  = res.payload_index;
  assign out_frame_result   = res.frame_result;
  assign out_session_status = res.session_status;
  assign out_checksum_mode  = res.checksum_mode;
  assign out_last           = res.last;
endmodule
`default_nettype wire

/* src/xmr_front.sv */
// protocol engine: accepts an input item, updates session state, builds results
// depends on xmr_pkg
`default_nettype none
module xmr_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              go,
  input  wire [1:0]        kind,
  input  wire [7:0]        rx_byte,
  input  wire              cfg_we,
  input  wire [1:0]        cfg_idx,
  input  wire [15:0]       cfg_data,
  output xmr_pkg::entry_t  ent
);
  import xmr_pkg::*;

  logic [15:0] period_r;
  logic [7:0]  crc_att_r, chk_att_r, max_to_r;
  session_t    ses_r, ses_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  start_r, start_nxt, blk_r, blk_nxt, cmp_r, cmp_nxt, fcb_r, fcb_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  sum_r, sum_nxt, lgb_r, lgb_nxt, retry_r, retry_nxt;
  logic        usec_r, usec_nxt;
  logic [15:0] ela_r, ela_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'd1000; crc_att_r <= 8'd15; chk_att_r <= 8'd2; max_to_r <= 8'd15;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PERIOD: period_r  <= cfg_data;
        CFG_CRCATT: crc_att_r <= cfg_data[7:0];
        CFG_CHKATT: chk_att_r <= cfg_data[7:0];
        default:    max_to_r  <= cfg_data[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ses_r <= SES_IDLE; pos_r <= '0; crc_r <= '0; sum_r <= '0; lgb_r <= '0;
      retry_r <= '0; usec_r <= 1'b0; ela_r <= '0;
    end else if (go) begin
      ses_r <= ses_nxt; pos_r <= pos_nxt; crc_r <= crc_nxt; sum_r <= sum_nxt;
      lgb_r <= lgb_nxt; retry_r <= retry_nxt; usec_r <= usec_nxt; ela_r <= ela_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      start_r <= start_nxt; blk_r <= blk_nxt; cmp_r <= cmp_nxt; fcb_r <= fcb_nxt;
    end
  end

  result_t     r0, r1;
  logic        two, n0;
  logic [15:0] ela_inc;
  logic [8:0]  limit_w;
  logic [7:0]  limit;
  logic [7:0]  frame, pos1;
  logic [1:0]  st;

  always_comb begin
    ses_nxt = ses_r; pos_nxt = pos_r; start_nxt = start_r; blk_nxt = blk_r;
    cmp_nxt = cmp_r; fcb_nxt = fcb_r; crc_nxt = crc_r; sum_nxt = sum_r;
    lgb_nxt = lgb_r; retry_nxt = retry_r; usec_nxt = usec_r; ela_nxt = ela_r;
    r0 = '0; r1 = '0; two = 1'b0; n0 = 1'b0; st = PS_NONE;
    ela_inc = (ela_r == 16'hffff) ? ela_r : ela_r + 16'd1;
    limit_w = {1'b0, crc_att_r} + {1'b0, chk_att_r};
    limit = limit_w[8] ? 8'hff : limit_w[7:0];
    frame = usec_r ? 8'd132 : 8'd133;
    pos1 = pos_r + 8'd1;
    case (kind)
      KIND_START: begin
        ses_nxt = SES_SETUP; pos_nxt = '0; crc_nxt = '0; sum_nxt = '0; lgb_nxt = '0;
        retry_nxt = '0; usec_nxt = 1'b0; ela_nxt = '0;
      end
      KIND_BYTE: begin
        if ((ses_r == SES_SETUP && rx_byte == B_SOH) || ses_r == SES_RECV) begin
          if (ses_r == SES_SETUP) begin
            retry_nxt = '0; ela_nxt = '0; ses_nxt = SES_RECV;
          end
          if (rx_byte == B_EOT && pos_r == 8'd0 && ses_r == SES_RECV) begin
            ses_nxt = SES_DONE;
            r0.tx_valid = 1'b1; r0.tx_byte = B_ACK;
            r1.tx_valid = 1'b1; r1.tx_byte = B_ACK; two = 1'b1;
          end else if (pos_r == 8'd1 && rx_byte == B_CAN && start_r == B_CAN) begin
            ses_nxt = SES_ABORT;
          end else begin
            if (pos_r == 8'd0) begin
              start_nxt = rx_byte; crc_nxt = '0; sum_nxt = '0;
            end else if (pos_r == 8'd1) blk_nxt = rx_byte;
            else if (pos_r == 8'd2) cmp_nxt = rx_byte;
            else if (pos_r <= 8'd130) begin
              r0.payload_valid = 1'b1; r0.payload_byte = rx_byte;
              r0.payload_index = 7'(pos_r - 8'd3); n0 = 1'b1;
              crc_nxt = crc_update(crc_r, rx_byte);
              sum_nxt = sum_r + rx_byte;
            end else if (pos_r == 8'd131) fcb_nxt = rx_byte;
            pos_nxt = pos1;
            if (pos1 >= frame) begin
              pos_nxt = '0; ela_nxt = '0;
              // frame checks; crc/sum use values before this byte
              // checksum frames end on the sum byte itself
              if (start_r != B_SOH || 8'(blk_r + cmp_r) != 8'hff) st = PS_BAD;
              else if (blk_r == lgb_r) st = PS_DUP;
              else if (blk_r != lgb_r + 8'd1) st = PS_BAD;
              else if (usec_r ? (rx_byte != sum_r)
                              : (fcb_r != crc_r[15:8] || rx_byte != crc_r[7:0]))
                st = PS_BAD;
              else st = PS_GOOD;
              if (st == PS_GOOD) lgb_nxt = lgb_r + 8'd1;
              if (n0) begin
                r1.tx_valid = 1'b1; r1.tx_byte = (st == PS_BAD) ? B_NAK : B_ACK;
                r1.frame_result = st; two = 1'b1;
              end else begin
                r0.tx_valid = 1'b1; r0.tx_byte = (st == PS_BAD) ? B_NAK : B_ACK;
                r0.frame_result = st;
              end
            end
          end
        end else if (ses_r == SES_SETUP && rx_byte == B_CAN) ses_nxt = SES_ABORT;
      end
      KIND_TICK: begin
        if (ses_r == SES_SETUP) begin
          ela_nxt = ela_inc;
          if (ela_inc > period_r) begin
            if (retry_r < limit) begin
              r0.tx_valid = 1'b1; r0.tx_byte = usec_r ? B_NAK : B_C;
              ela_nxt = '0; retry_nxt = retry_r + 8'd1;
            end else begin
              ses_nxt = SES_FAIL;
              r0.tx_valid = 1'b1; r0.tx_byte = B_CAN;
              r1.tx_valid = 1'b1; r1.tx_byte = B_CAN; two = 1'b1;
            end
            if (retry_nxt >= crc_att_r) usec_nxt = 1'b1;
          end
        end else if (ses_r == SES_RECV) begin
          ela_nxt = ela_inc;
          if (ela_inc > period_r) begin
            if (retry_r > max_to_r) ses_nxt = SES_ABORT;
            else begin
              r0.tx_valid = 1'b1; r0.tx_byte = B_NAK; pos_nxt = '0;
              if (retry_r != 8'hff) retry_nxt = retry_r + 8'd1;
              ela_nxt = '0;
            end
          end
        end
      end
      default: ;
    endcase
    r0.session_status = ses_nxt; r0.checksum_mode = usec_nxt; r0.last = !two;
    r1.session_status = ses_nxt; r1.checksum_mode = usec_nxt; r1.last = 1'b1;
    ent.two = two; ent.r0 = r0; ent.r1 = r1;
  end
endmodule
`default_nettype wire

/* src/xmr_back.sv */
// entry queue and result sequencer: splits entries into result items
// depends on xmr_pkg
`default_nettype none
module xmr_back #(
  parameter int Depth = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  xmr_pkg::entry_t  ent,
  output logic             full,
  input  wire              pop,
  output logic             empty,
  output xmr_pkg::result_t res
);
  import xmr_pkg::*;
  localparam int AW = $clog2(Depth);

  entry_t          mem_r [Depth];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic            half_r;
  logic            done;

  assign full  = cnt_r == (AW+1)'(Depth);
  assign empty = cnt_r == '0;
  assign res   = half_r ? mem_r[rp_r].r1 : mem_r[rp_r].r0;
  // entry retires after its last result item
  assign done  = pop && !empty && (half_r || !mem_r[rp_r].two);

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; half_r <= 1'b0;
    end else begin
      if (push && !full) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (done) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      if (pop && !empty) half_r <= !done;
      cnt_r <= cnt_r + (AW+1)'(push && !full) - (AW+1)'(done);
    end
  end
endmodule
`default_nettype wire

/* src/xmr_checker.sv */
// port-level checks of the xmodem receiver, bound to the top level
// depends on xmodem_receiver_defines.svh
`default_nettype none
`include "xmodem_receiver_defines.svh"
module xmr_props (
  input wire       clk,
  input wire       rst_n,
  input wire       out_empty,
  input wire       out_pop,
  input wire       out_tx_valid,
  input wire [7:0] out_tx_byte,
  input wire       out_payload_valid,
  input wire [2:0] out_session_status,
  input wire       out_last
);
  `XR_ASSERT_IMP(a_no_both, !out_empty, !(out_tx_valid && out_payload_valid))
  `XR_ASSERT_IMP(a_status_rng, !out_empty, out_session_status <= 3'd5)
  `XR_ASSERT_IMP(a_tx_zero, !out_empty && !out_tx_valid, out_tx_byte == 8'd0)
  `XR_ASSERT_NXT(a_pay_pair, !out_empty && out_pop && !out_last, !out_empty)
endmodule

bind xmodem_receiver xmr_props u_props (.*);
`default_nettype wire

/* bench/xmr_checker.sv */
// checker for the xmodem receiver: watches the item and result queues and
// predicts every result from accepted items and register writes
// depends on xmr_pkg
module xmr_checker (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_push,
  input  wire              in_full,
  input  wire [1:0]        in_kind,
  input  wire [7:0]        in_rx_byte,
  input  wire              cfg_valid,
  input  wire              cfg_ready,
  input  wire [1:0]        cfg_index,
  input  wire [15:0]       cfg_data,
  input  wire              out_empty,
  input  wire              out_pop,
  input  xmr_pkg::result_t got,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import xmr_pkg::*;

  logic [15:0] period;
  logic [7:0]  crc_tries, sum_tries, timeout_cap;
  session_t    ses;
  logic [7:0]  pos, head, blk, blk_inv, chk1, good_blk, tries;
  logic [15:0] crc;
  logic [7:0]  sum;
  logic        sum_mode;
  logic [15:0] ticks;
  result_t     expected_q[$];
  result_t     pend[$];

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c ^= {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic result_t tx(logic [7:0] b);
    result_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte = b;
    return r;
  endfunction

  function automatic logic [1:0] judge(logic [7:0] second);
    if (head != B_SOH) return PS_BAD;
    if (8'(blk + blk_inv) != 8'hff) return PS_BAD;
    if (blk == good_blk) return PS_DUP;
    if (blk != 8'(good_blk + 1)) return PS_BAD;
    if (sum_mode) begin
      if (chk1 != sum) return PS_BAD;
    end else if (chk1 != crc[15:8] || second != crc[7:0]) return PS_BAD;
    good_blk = 8'(good_blk + 1);
    return PS_GOOD;
  endfunction

  task automatic frame_byte(logic [7:0] b);
    result_t r;
    logic [1:0] st;
    logic [7:0] p;
    p = pos;
    if (b == B_EOT && p == 0) begin
      ses = SES_DONE;
      pend.push_back(tx(B_ACK));
      pend.push_back(tx(B_ACK));
      return;
    end
    if (p == 1 && b == B_CAN && head == B_CAN) begin
      ses = SES_ABORT;
      return;
    end
    if (p == 0) begin
      head = b; crc = '0; sum = '0;
    end else if (p == 1) blk = b;
    else if (p == 2) blk_inv = b;
    else if (p <= 130) begin
      r = '0;
      r.payload_valid = 1'b1;
      r.payload_byte = b;
      r.payload_index = 7'(p - 3);
      pend.push_back(r);
      crc = crc_step(crc, b);
      sum = sum + b;
    end else if (p == 131) chk1 = b;
    p++;
    if (p >= (sum_mode ? 132 : 133)) begin
      p = 0;
      st = judge(b);
      r = tx(st == PS_BAD ? B_NAK : B_ACK);
      r.frame_result = st;
      pend.push_back(r);
      ticks = 0;
    end
    pos = p;
  endtask

  task automatic predict(logic [1:0] kind, logic [7:0] b);
    result_t r;
    logic [8:0] lim;
    pend.delete();
    if (kind == KIND_START) begin
      ses = SES_SETUP; pos = 0; crc = 0; sum = 0; good_blk = 0;
      tries = 0; sum_mode = 0; ticks = 0;
    end else if (kind == KIND_BYTE && ses == SES_SETUP) begin
      if (b == B_SOH) begin
        tries = 0; ticks = 0; ses = SES_RECV;
        frame_byte(b);
      end else if (b == B_CAN) ses = SES_ABORT;
    end else if (kind == KIND_BYTE && ses == SES_RECV) frame_byte(b);
    else if (kind == KIND_TICK && ses == SES_SETUP) begin
      if (ticks != 16'hffff) ticks++;
      if (ticks > period) begin
        lim = crc_tries + sum_tries;
        if (lim > 255) lim = 255;
        if (tries < lim) begin
          pend.push_back(tx(sum_mode ? B_NAK : B_C));
          ticks = 0;
          tries++;
        end else begin
          ses = SES_FAIL;
          pend.push_back(tx(B_CAN));
          pend.push_back(tx(B_CAN));
        end
        if (tries >= crc_tries) sum_mode = 1;
      end
    end else if (kind == KIND_TICK && ses == SES_RECV) begin
      if (ticks != 16'hffff) ticks++;
      if (ticks > period) begin
        if (tries > timeout_cap) ses = SES_ABORT;
        else begin
          pend.push_back(tx(B_NAK));
          pos = 0;
          if (tries != 8'hff) tries++;
          ticks = 0;
        end
      end
    end
    if (pend.size() == 0) pend.push_back('0);
    foreach (pend[k]) begin
      r = pend[k];
      r.session_status = ses;
      r.checksum_mode = sum_mode;
      r.last = (k == pend.size() - 1);
      expected_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      period <= 16'd1000; crc_tries <= 8'd15; sum_tries <= 8'd2; timeout_cap <= 8'd15;
      ses = SES_IDLE; pos = 0; crc = 0; sum = 0; good_blk = 0; tries = 0;
      sum_mode = 0; ticks = 0; head = 0; blk = 0; blk_inv = 0; chk1 = 0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        case (cfg_index)
          CFG_PERIOD: period <= cfg_data;
          CFG_CRCATT: crc_tries <= cfg_data[7:0];
          CFG_CHKATT: sum_tries <= cfg_data[7:0];
          CFG_MAXTO:  timeout_cap <= cfg_data[7:0];
        endcase
      if (in_push && !in_full) predict(in_kind, in_rx_byte);
      if (out_pop && !out_empty) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== got) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, e, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

/* bench/xmodem_receiver_tb.sv */
// stimulus and verdict for the xmodem receiver
// depends on xmr_pkg, xmodem_receiver and xmr_checker
module xmodem_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xmr_pkg::*;

  logic clk = 0, rst_n = 0;
  logic in_push = 0, cfg_valid = 0, out_pop = 0;
  logic [1:0] in_kind = KIND_TICK, cfg_index = CFG_PERIOD;
  logic [7:0] in_rx_byte = 0;
  logic [15:0] cfg_data = 0;
  wire in_full, cfg_ready, out_empty;
  wire result_t got;
  int fail_count, pending;
  int cycles = 0;
  bit quiet = 0;      // no idling near the end
  bit hold_off = 0;   // receiver stall for the fill-up test
  logic [7:0] lastblk;

  always #5 clk = ~clk;

  xmodem_receiver dut (
    .clk, .rst_n, .in_push, .in_full, .in_kind, .in_rx_byte,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .out_empty, .out_pop,
    .out_tx_valid(got.tx_valid), .out_tx_byte(got.tx_byte),
    .out_payload_valid(got.payload_valid), .out_payload_byte(got.payload_byte),
    .out_payload_index(got.payload_index), .out_frame_result(got.frame_result),
    .out_session_status(got.session_status), .out_checksum_mode(got.checksum_mode),
    .out_last(got.last)
  );

  xmr_checker chk (
    .clk, .rst_n, .in_push, .in_full, .in_kind, .in_rx_byte, .cfg_valid,
    .cfg_ready, .cfg_index, .cfg_data, .out_empty, .out_pop, .got,
    .fail_count, .pending
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver side: random pop bursts, or a long hold-off when asked
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_pop <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        out_pop <= 0;
        repeat (n - 1) @(negedge clk);
      end else out_pop <= 1;
    end
  end

  // one item through the input queue, with random sender gaps
  // push stays high after the item; drain or the caller drops it
  task automatic send(logic [1:0] k, logic [7:0] b);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_push <= 0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_push <= 1;
    in_kind <= k;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_push <= 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  // one packet: blk number, optional corruption, crc or sum trailer
  task automatic packet(logic [7:0] blk, bit sum_mode, int damage);
    logic [7:0] data[128];
    logic [15:0] c;
    logic [7:0] s;
    c = 0;
    s = 0;
    foreach (data[i]) begin
      data[i] = 8'($urandom);
      c ^= {data[i], 8'h00};
      for (int j = 0; j < 8; j++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      s += data[i];
    end
    send(KIND_BYTE, damage == 1 ? 8'($urandom) : B_SOH);
    send(KIND_BYTE, blk);
    send(KIND_BYTE, damage == 2 ? ~blk ^ 8'h10 : ~blk);
    foreach (data[i]) send(KIND_BYTE, data[i]);
    if (sum_mode) send(KIND_BYTE, damage == 3 ? s ^ 8'h01 : s);
    else begin
      send(KIND_BYTE, damage == 3 ? c[15:8] ^ 8'h80 : c[15:8]);
      send(KIND_BYTE, c[7:0]);
    end
  endtask

  task automatic session(bit sum_mode);
    int pk;
    lastblk = 0;
    send(KIND_START, 8'($urandom));
    if (sum_mode) begin
      // let setup fall back to checksum mode with tiny period
      repeat (3) send(KIND_TICK, 8'($urandom));
    end
    pk = $urandom_range(1, 2);
    for (int i = 0; i < pk; i++) begin
      case ($urandom_range(0, 9))
        0: packet(lastblk, sum_mode, 0);                // duplicate
        1: packet(8'(lastblk + 1), sum_mode, $urandom_range(1, 3));
        2: packet(8'($urandom), sum_mode, 0);           // wrong sequence
        3: begin
          // partial packet, then ticks that may time out
          send(KIND_BYTE, B_SOH);
          repeat ($urandom_range(0, 5)) send(KIND_BYTE, 8'($urandom));
          repeat (3) send(KIND_TICK, 8'h00);
        end
        default: begin
          packet(8'(lastblk + 1), sum_mode, 0);
          lastblk++;
        end
      endcase
    end
    case ($urandom_range(0, 3))
      0: begin send(KIND_BYTE, B_CAN); send(KIND_BYTE, B_CAN); end
      1: send(KIND_BYTE, 8'($urandom));
      default: send(KIND_BYTE, B_EOT);
    endcase
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: reset defaults, idle items, unknown kind, start, setup bytes
    send(KIND_BYTE, 8'hff);
    send(KIND_TICK, 8'h00);
    send(2'd3, 8'haa);
    send(KIND_START, 8'h55);
    send(KIND_BYTE, 8'h00);
    send(KIND_BYTE, B_CAN);           // setup abort
    send(KIND_TICK, 8'h00);
    drain();
    // tiny period: setup 'C' then NAK fallback then CAN CAN
    write_reg(CFG_PERIOD, 16'd1);
    write_reg(CFG_CRCATT, 16'd1);
    write_reg(CFG_CHKATT, 16'd1);
    write_reg(CFG_MAXTO, 16'd0);
    send(KIND_START, 8'h00);
    repeat (8) send(KIND_TICK, 8'h00);
    // zero attempts: immediate failure
    drain();
    write_reg(CFG_CRCATT, 16'd0);
    write_reg(CFG_CHKATT, 16'd0);
    send(KIND_START, 8'h00);
    repeat (3) send(KIND_TICK, 8'h00);
    // receive timeouts with max_timeouts 0, then eot during setup, which is ignored
    send(KIND_START, 8'h00);
    send(KIND_BYTE, B_SOH);
    repeat (6) send(KIND_TICK, 8'h00);
    send(KIND_START, 8'h00);
    send(KIND_BYTE, B_EOT);
    drain();

    // extremes: max attempts
    write_reg(CFG_CRCATT, 16'd255);
    write_reg(CFG_CHKATT, 16'd255);
    write_reg(CFG_MAXTO, 16'd255);
    send(KIND_START, 8'h00);
    repeat (30) send(KIND_TICK, 8'h00);
    drain();

    // crc-mode sessions, long period so ticks never time out
    write_reg(CFG_PERIOD, 16'hffff);
    write_reg(CFG_MAXTO, 16'd3);
    repeat (3) session(0);
    drain();

    // fill-up: receiver stalls while sender keeps pushing
    hold_off = 1;
    fork
      begin
        repeat (12) send(KIND_TICK, 8'h00);
        in_push <= 0;
      end
      begin repeat (200) @(negedge clk); hold_off = 0; end
    join
    drain();

    // checksum-mode sessions: fallback right away
    write_reg(CFG_PERIOD, 16'd0);
    write_reg(CFG_CRCATT, 16'd0);
    write_reg(CFG_CHKATT, 16'd200);
    repeat (3) session(1);
    drain();

    write_reg(CFG_PERIOD, 16'd1000);
    write_reg(CFG_CRCATT, 16'd15);
    write_reg(CFG_CHKATT, 16'd2);
    write_reg(CFG_MAXTO, 16'd15);
    repeat (3) session(0);
    quiet = 1;
    repeat (40) send(KIND_BYTE, 8'($urandom));
    drain();
    repeat (20) @(negedge clk);

    if (fail_count == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
